/* rtl/csc_pkg.sv */
package csc_pkg;

  // capacity of the sequence store
  localparam int MaxLen = 64;
  localparam int ElemW  = 32;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int CountW = $clog2(MaxLen + 1);

  typedef logic [ElemW-1:0]  elem_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store;      // accepted input item; written into the store unless a repeat or full
    logic setup;      // fix the length and start the search at candidate one
    logic cmp_step;   // elements equal, advance both read pointers
    logic cand_next;  // move on to the next candidate start
    logic take_best;  // with cand_next: the candidate becomes the best start
    logic emit_init;  // point the read at the best start
    logic emit_push;  // load the output register and advance
  } csc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_one;      // the adjusted length is one
    logic lt;         // candidate element below best element
    logic gt;         // candidate element above best element
    logic k_last;     // last element position of a comparison
    logic i_last;     // last candidate start
    logic e_last;     // last element of the emitted rotation
    logic out_free;   // output register can take an item
  } csc_stat_t;

endpackage

/* rtl/cyclic_sequence_canonicalizer.sv */
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | element_value_i, is_last_i
// out     | output    | out_valid_o / out_stall_i | out_value_o, out_last_o, overflowed_o
//
// a non-final item is taken without a stall; the final item starts the search
// search: each element compare reads the two store read ports, then evaluates,
// over every candidate start; after it each result item is read and registered
// reset is asynchronous, active low; no clearing pass is needed
// input is stalled from the final item until the last result is registered
// a stalled output holds the emission, the output register keeps its item
module cyclic_sequence_canonicalizer import csc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  elem_t element_value_i,
  input  logic  is_last_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output elem_t out_value_o,
  output logic  out_last_o,
  output logic  overflowed_o
);

  csc_cmd_t  cmd;
  csc_stat_t stat;

  // sequencer
  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_last_i  (is_last_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, search pointers and output register
  csc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .element_value_i (element_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_value_o     (out_value_o),
    .out_last_o      (out_last_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

/* rtl/csc_ram.sv */
module csc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/csc_dp.sv */
module csc_dp import csc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csc_cmd_t  cmd_i,
  output csc_stat_t stat_o,
  input  elem_t     element_value_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output elem_t     out_value_o,
  output logic      out_last_o,
  output logic      overflowed_o
);

  count_t count_q, count_d;
  logic   ovf_q, ovf_d;
  elem_t  first_q, first_d;
  elem_t  prev_q, prev_d;
  count_t n_q, n_d;
  count_t i_q, i_d;
  addr_t  best_q, best_d;
  addr_t  ra_q, ra_d;
  addr_t  rb_q, rb_d;
  addr_t  k_q, k_d;
  logic   out_valid_q, out_valid_d;
  elem_t  out_value_q, out_value_d;
  logic   out_last_q, out_last_d;
  logic   out_ovf_q, out_ovf_d;

  logic   we;
  elem_t  rd_a, rd_b;
  count_t n_adj;
  count_t i_inc;
  addr_t  best_new;

  // advance a store pointer, wrapping at the sequence length
  function automatic addr_t wrap_inc(addr_t a, count_t n);
    addr_t r;
    r = a + addr_t'(1);
    if (count_t'(a) + count_t'(1) == n) begin
      r = '0;
    end
    return r;
  endfunction

  // element store
  assign we = cmd_i.store &&
              ((count_q == '0) ||
               ((element_value_i != prev_q) && (count_q < count_t'(MaxLen))));

  csc_ram #(
    .Width (ElemW),
    .Depth (MaxLen)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (count_q[AddrW-1:0]),
    .wdata_i   (element_value_i),
    .raddr_a_i (ra_q),
    .raddr_b_i (rb_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // length after dropping a final element equal to the first
  always_comb begin
    n_adj = count_q;
    if ((count_q >= count_t'(2)) && (prev_q == first_q)) begin
      n_adj = count_q - count_t'(1);
    end
  end

  assign i_inc    = i_q + count_t'(1);
  assign best_new = cmd_i.take_best ? i_q[AddrW-1:0] : best_q;

  // status
  assign stat_o.n_one    = (n_adj == count_t'(1));
  assign stat_o.lt       = (rd_a < rd_b);
  assign stat_o.gt       = (rd_a > rd_b);
  assign stat_o.k_last   = (count_t'(k_q) + count_t'(1) == n_q);
  assign stat_o.i_last   = (i_inc == n_q);
  assign stat_o.e_last   = (count_t'(k_q) + count_t'(1) == n_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // next state of the datapath registers
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    first_d     = first_q;
    prev_d      = prev_q;
    n_d         = n_q;
    i_d         = i_q;
    best_d      = best_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    // loading, with duplicate and capacity drop
    if (cmd_i.store) begin
      if (count_q == '0) begin
        first_d = element_value_i;
        prev_d  = element_value_i;
        count_d = count_t'(1);
      end else if (element_value_i != prev_q) begin
        if (count_q < count_t'(MaxLen)) begin
          prev_d  = element_value_i;
          count_d = count_q + count_t'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end

    // start of the rotation search
    if (cmd_i.setup) begin
      n_d    = n_adj;
      best_d = '0;
      i_d    = count_t'(1);
      ra_d   = addr_t'(1);
      rb_d   = '0;
      k_d    = '0;
    end

    // equal elements, next position of both rotations
    if (cmd_i.cmp_step) begin
      ra_d = wrap_inc(ra_q, n_q);
      rb_d = wrap_inc(rb_q, n_q);
      k_d  = k_q + addr_t'(1);
    end

    // next candidate start
    if (cmd_i.cand_next) begin
      best_d = best_new;
      i_d    = i_inc;
      ra_d   = i_inc[AddrW-1:0];
      rb_d   = best_new;
      k_d    = '0;
    end

    // emission of the best rotation
    if (cmd_i.emit_init) begin
      ra_d = best_q;
      k_d  = '0;
    end

    if (cmd_i.emit_push) begin
      out_valid_d = 1'b1;
      out_value_d = rd_a;
      out_last_d  = stat_o.e_last;
      out_ovf_d   = ovf_q;
      ra_d        = wrap_inc(ra_q, n_q);
      k_d         = k_q + addr_t'(1);
      if (stat_o.e_last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    prev_q      <= prev_d;
    n_q         <= n_d;
    i_q         <= i_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    k_q         <= k_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;
  assign overflowed_o = out_ovf_q;

endmodule

/* rtl/csc_ctrl.sv */
module csc_ctrl import csc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      is_last_i,
  output logic      in_stall_o,
  input  csc_stat_t stat_i,
  output csc_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StLoad    = 7'b0000001,
    StPrep    = 7'b0000010,
    StCmpRd   = 7'b0000100,
    StCmpEv   = 7'b0001000,
    StEmitSet = 7'b0010000,
    StEmitRd  = 7'b0100000,
    StEmitOut = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != StLoad);

  // sequencing of load, search and emission
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (is_last_i) begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.n_one ? StEmitSet : StCmpRd;
      end
      StCmpRd: begin
        state_d = StCmpEv;
      end
      StCmpEv: begin
        if (stat_i.lt || stat_i.gt || stat_i.k_last) begin
          cmd_o.cand_next = 1'b1;
          cmd_o.take_best = stat_i.lt;
          state_d         = stat_i.i_last ? StEmitSet : StCmpRd;
        end else begin
          cmd_o.cmp_step = 1'b1;
          state_d        = StCmpRd;
        end
      end
      StEmitSet: begin
        cmd_o.emit_init = 1'b1;
        state_d         = StEmitRd;
      end
      StEmitRd: begin
        state_d = StEmitOut;
      end
      StEmitOut: begin
        if (stat_i.out_free) begin
          cmd_o.emit_push = 1'b1;
          state_d         = stat_i.e_last ? StLoad : StEmitRd;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
